### rtl/core/http2_frame_receiver_defines.svh
// assertion macros used by the port checker file
`ifndef HTTP2_FRAME_RECEIVER_DEFINES_SVH
`define HTTP2_FRAME_RECEIVER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define H2R_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("h2r check failed");
// next-cycle implication checked outside reset
`define H2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("h2r check failed");
`endif

### rtl/core/h2r_pkg.sv
// shared types and constants of the http/2 frame receiver
package h2r_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned OutBits = 4 + 1 + 8 + 8 + 24 + 31 + 1 + 2 + 3 + 64 + 31;
  localparam int unsigned OutBytes = (OutBits + 7) / 8;

  typedef enum logic [3:0] {
    ST_PREFACE   = 4'd0,
    ST_FIRST_HDR = 4'd1,
    ST_HEADER    = 4'd2,
    ST_PADLEN    = 4'd3,
    ST_PRIORITY  = 4'd4,
    ST_SERVICE   = 4'd5,
    ST_SETTINGS  = 4'd6,
    ST_DATA      = 4'd7,
    ST_HBLOCK    = 4'd8,
    ST_CONT      = 4'd9,
    ST_SKIP      = 4'd10,
    ST_LATCHED   = 4'd11,
    ST_DEAD      = 4'd12
  } pstate_t;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_PING = 2'd1;
  localparam logic [1:0] ACT_SACK = 2'd2;
  localparam logic [1:0] ACT_DROP = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_PROTO    = 3'd1;
  localparam logic [2:0] ERR_SIZE     = 3'd2;
  localparam logic [2:0] ERR_PREFACE  = 3'd3;
  localparam logic [2:0] ERR_UNSUPP   = 3'd4;
  localparam logic [2:0] ERR_PEER     = 3'd5;

  localparam logic [3:0] CLS_PREFACE = 4'd0;
  localparam logic [3:0] CLS_HEADER  = 4'd1;
  localparam logic [3:0] CLS_IGNORED = 4'd9;
  localparam logic [3:0] CLS_DEAD    = 4'd10;

  localparam logic [7:0] FL_ACK      = 8'h01;
  localparam logic [7:0] FL_PADDED   = 8'h08;
  localparam logic [7:0] FL_PRIORITY = 8'h20;

  localparam logic [7:0] FT_DATA     = 8'd0;
  localparam logic [7:0] FT_HEADERS  = 8'd1;
  localparam logic [7:0] FT_PRIO     = 8'd2;
  localparam logic [7:0] FT_RST      = 8'd3;
  localparam logic [7:0] FT_SETTINGS = 8'd4;
  localparam logic [7:0] FT_PUSH     = 8'd5;
  localparam logic [7:0] FT_PING     = 8'd6;
  localparam logic [7:0] FT_GOAWAY   = 8'd7;
  localparam logic [7:0] FT_WINDOW   = 8'd8;
  localparam logic [7:0] FT_CONT     = 8'd9;

  typedef struct packed {
    logic [3:0]  byte_class;
    logic        header_done;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [23:0] frame_length;
    logic [30:0] frame_stream;
    logic        frame_end;
    logic [1:0]  action;
    logic [2:0]  error_code;
    logic [63:0] ping_payload;
    logic [30:0] goaway_last_stream;
  } result_t;

  // preface byte by index
  function automatic logic [7:0] preface_byte(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'h50;
      5'd1:  v = 8'h52;
      5'd2:  v = 8'h49;
      5'd3:  v = 8'h20;
      5'd4:  v = 8'h2a;
      5'd5:  v = 8'h20;
      5'd6:  v = 8'h48;
      5'd7:  v = 8'h54;
      5'd8:  v = 8'h54;
      5'd9:  v = 8'h50;
      5'd10: v = 8'h2f;
      5'd11: v = 8'h32;
      5'd12: v = 8'h2e;
      5'd13: v = 8'h30;
      5'd14: v = 8'h0d;
      5'd15: v = 8'h0a;
      5'd16: v = 8'h0d;
      5'd17: v = 8'h0a;
      5'd18: v = 8'h53;
      5'd19: v = 8'h4d;
      5'd20: v = 8'h0d;
      5'd21: v = 8'h0a;
      5'd22: v = 8'h0d;
      5'd23: v = 8'h0a;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // payload length is a multiple of six settings bytes
  function automatic logic mult6(input logic [23:0] n);
    logic [23:0] q;
    logic [2:0]  r;
    q = 24'((48'(n) * 48'd11184811) >> 26);
    r = 3'(n - 24'(q * 24'd6));
    return r == 3'd0;
  endfunction

endpackage

### rtl/core/h2r_front.sv
// front end: accepts stream bytes and runs the frame parser
module h2r_front import h2r_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_ready,
  output logic       res_valid,
  output result_t    res_data,
  input  logic       res_ready
);

  pstate_t     st_r, st_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [7:0]  type_r, type_nxt, flags_r, flags_nxt, pad_r, pad_nxt;
  logic [30:0] strm_r, strm_nxt, last_r, last_nxt;
  logic [23:0] rem_r, rem_nxt, seg_r, seg_nxt, hlen_r, hlen_nxt;

  logic        take;
  result_t     res;

  assign in_ready = res_ready;
  assign take = in_valid && in_ready;
  assign res_valid = take;
  assign res_data = res;

  // per-byte parser step
  always_comb begin
    logic [23:0] l, rem1, seg1, body;
    logic [7:0]  t, f;
    logic [30:0] s;
    logic [63:0] shn;
    logic [31:0] low;
    logic        e1;
    logic [2:0]  e;
    st_nxt = st_r; cnt_nxt = cnt_r; sh_nxt = sh_r; type_nxt = type_r;
    flags_nxt = flags_r; pad_nxt = pad_r; strm_nxt = strm_r; last_nxt = last_r;
    rem_nxt = rem_r; seg_nxt = seg_r; hlen_nxt = hlen_r;
    res = '0;
    res.byte_class = CLS_DEAD;
    l = sh_r[63:40]; t = sh_r[39:32]; f = sh_r[31:24];
    s = {sh_r[22:0], in_byte};
    shn = {sh_r[55:0], in_byte};
    low = shn[31:0];
    rem1 = rem_r - 24'd1;
    seg1 = seg_r - 24'd1;
    body = '0; e1 = 1'b0; e = ERR_NONE;
    case (st_r)
      ST_PREFACE: begin
        res.byte_class = CLS_PREFACE;
        if (in_byte != preface_byte(cnt_r)) begin
          st_nxt = ST_DEAD; res.action = ACT_DROP; res.error_code = ERR_PREFACE;
        end else if (cnt_r == 5'd23) begin
          st_nxt = ST_FIRST_HDR; cnt_nxt = '0; sh_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_FIRST_HDR, ST_HEADER: begin
        res.byte_class = CLS_HEADER;
        if (cnt_r != 5'd8) begin
          sh_nxt = shn; cnt_nxt = cnt_r + 5'd1;
        end else begin
          res.header_done = 1'b1;
          type_nxt = t; flags_nxt = f; strm_nxt = s; hlen_nxt = l; rem_nxt = l;
          pad_nxt = '0; sh_nxt = '0; cnt_nxt = '0; st_nxt = ST_HEADER;
          if (st_r == ST_FIRST_HDR) begin
            if (t != FT_SETTINGS || f[0] || s != '0) e = ERR_PROTO;
            if (l != '0 && (!mult6(l) || f[0])) e = ERR_SIZE;
            e1 = e != ERR_NONE;
          end
          if (e1) begin
            st_nxt = ST_LATCHED; res.error_code = e;
          end else begin
            case (t)
              FT_DATA, FT_HEADERS: begin
                if ((f & FL_PADDED) != '0) begin
                  if (l == '0) begin
                    st_nxt = ST_LATCHED; res.error_code = ERR_SIZE;
                  end else begin
                    st_nxt = ST_PADLEN; seg_nxt = 24'd1;
                  end
                end else if (t == FT_HEADERS && (f & FL_PRIORITY) != '0) begin
                  if (l < 24'd5) begin
                    st_nxt = ST_LATCHED; res.error_code = ERR_SIZE;
                  end else begin
                    st_nxt = ST_PRIORITY; seg_nxt = 24'd5;
                  end
                end else if (l != '0) begin
                  st_nxt = (t == FT_DATA) ? ST_DATA : ST_HBLOCK; seg_nxt = l;
                end
              end
              FT_PRIO, FT_PUSH: begin
                st_nxt = ST_DEAD; res.action = ACT_DROP; res.error_code = ERR_UNSUPP;
              end
              FT_RST, FT_WINDOW: begin
                if (l != 24'd4) begin
                  st_nxt = ST_LATCHED; res.error_code = ERR_SIZE;
                end else begin
                  st_nxt = ST_SERVICE; seg_nxt = 24'd4;
                end
              end
              FT_SETTINGS: begin
                if (s != '0) begin
                  st_nxt = ST_LATCHED; res.error_code = ERR_PROTO;
                end else if (!mult6(l) || (f[0] && l != '0)) begin
                  st_nxt = ST_LATCHED; res.error_code = ERR_SIZE;
                end else if (l != '0) begin
                  st_nxt = ST_SETTINGS; seg_nxt = 24'd6;
                end else if (!f[0]) begin
                  res.action = ACT_SACK;
                end
              end
              FT_PING, FT_GOAWAY: begin
                if (s != '0) begin
                  st_nxt = ST_LATCHED; res.error_code = ERR_PROTO;
                end else if ((t == FT_PING) ? (l != 24'd8) : (l < 24'd8)) begin
                  st_nxt = ST_LATCHED; res.error_code = ERR_SIZE;
                end else begin
                  st_nxt = ST_SERVICE; seg_nxt = 24'd8;
                end
              end
              FT_CONT: begin
                if (l != '0) begin
                  st_nxt = ST_CONT; seg_nxt = l;
                end
              end
              default: begin
                if (l != '0) begin
                  st_nxt = ST_SKIP; seg_nxt = l;
                end
              end
            endcase
          end
          res.frame_end = st_nxt == ST_HEADER;
        end
      end
      ST_PADLEN, ST_PRIORITY, ST_SERVICE, ST_SETTINGS, ST_DATA, ST_HBLOCK,
      ST_CONT, ST_SKIP: begin
        res.byte_class = 4'(st_r) - 4'd1;
        sh_nxt = shn; rem_nxt = rem1; seg_nxt = seg1;
        if (seg1 == '0) begin
          case (st_r)
            ST_PADLEN: begin
              pad_nxt = in_byte;
              if (type_r == FT_HEADERS && (flags_r & FL_PRIORITY) != '0) begin
                if (rem1 < 24'd5) begin
                  st_nxt = ST_LATCHED; res.error_code = ERR_SIZE;
                end else if (24'(in_byte) > rem1 - 24'd5) begin
                  st_nxt = ST_LATCHED; res.error_code = ERR_PROTO;
                end else begin
                  st_nxt = ST_PRIORITY; seg_nxt = 24'd5; sh_nxt = '0;
                end
              end else if (24'(in_byte) > rem1) begin
                st_nxt = ST_LATCHED; res.error_code = ERR_PROTO;
              end else begin
                body = rem1 - 24'(in_byte);
                if (body != '0) begin
                  st_nxt = (type_r == FT_DATA) ? ST_DATA : ST_HBLOCK;
                  seg_nxt = body; sh_nxt = '0;
                end else if (rem1 != '0) begin
                  st_nxt = ST_SKIP; seg_nxt = rem1; sh_nxt = '0;
                end
              end
            end
            ST_PRIORITY: begin
              body = (rem1 >= 24'(pad_r)) ? rem1 - 24'(pad_r) : '0;
              if (body != '0) begin
                st_nxt = ST_HBLOCK; seg_nxt = body; sh_nxt = '0;
              end else if (rem1 != '0) begin
                st_nxt = ST_SKIP; seg_nxt = rem1; sh_nxt = '0;
              end
            end
            ST_SETTINGS: begin
              if (rem1 != '0) begin
                seg_nxt = 24'd6; sh_nxt = '0;
              end else begin
                res.action = ACT_SACK;
              end
            end
            ST_SERVICE: begin
              if (type_r == FT_RST) begin
                if (low != '0) begin
                  st_nxt = ST_DEAD; res.action = ACT_DROP; res.error_code = ERR_PEER;
                end
              end else if (type_r == FT_PING) begin
                if (!flags_r[0]) begin
                  res.action = ACT_PING; res.ping_payload = shn;
                end
              end else if (type_r == FT_GOAWAY) begin
                last_nxt = shn[62:32];
                if (low != '0) begin
                  st_nxt = ST_DEAD; res.action = ACT_DROP; res.error_code = ERR_PEER;
                end else if (rem1 != '0) begin
                  st_nxt = ST_SKIP; seg_nxt = rem1; sh_nxt = '0;
                end
              end
            end
            ST_DATA, ST_HBLOCK: begin
              if (rem1 != '0) begin
                st_nxt = ST_SKIP; seg_nxt = rem1; sh_nxt = '0;
              end
            end
            default: ;
          endcase
        end
        if (st_nxt != ST_LATCHED && st_nxt != ST_DEAD && rem1 == '0) begin
          res.frame_end = 1'b1; st_nxt = ST_HEADER; cnt_nxt = '0; sh_nxt = '0;
        end
      end
      ST_LATCHED: res.byte_class = CLS_IGNORED;
      default: st_nxt = ST_DEAD;
    endcase
    res.frame_type = type_nxt;
    res.frame_flags = flags_nxt;
    res.frame_length = hlen_nxt;
    res.frame_stream = strm_nxt;
    res.goaway_last_stream = last_nxt;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_PREFACE; cnt_r <= '0; sh_r <= '0; type_r <= '0; flags_r <= '0;
      pad_r <= '0; strm_r <= '0; last_r <= '0; rem_r <= '0; seg_r <= '0; hlen_r <= '0;
    end else if (take) begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; sh_r <= sh_nxt; type_r <= type_nxt;
      flags_r <= flags_nxt; pad_r <= pad_nxt; strm_r <= strm_nxt; last_r <= last_nxt;
      rem_r <= rem_nxt; seg_r <= seg_nxt; hlen_r <= hlen_nxt;
    end
  end

endmodule

### rtl/core/h2r_queue.sv
// result queue between parser and output port
module h2r_queue import h2r_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_valid,
  input  result_t wr_data,
  output logic    wr_ready,
  output logic    rd_valid,
  output result_t rd_data,
  input  logic    rd_ready
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  result_t        mem_r [Depth];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign wr_ready = cnt_r != (AW+1)'(Depth);
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + AW'(1);
      if (pop) rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

### rtl/core/h2r_back.sv
// back end: output register that packs results onto the stream port
module h2r_back import h2r_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  result_t               q_data,
  output logic                  q_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OutBytes*8-1:0] out_tdata
);

  logic    vld_r;
  result_t dat_r;

  assign q_ready = !vld_r || out_tready;
  assign out_tvalid = vld_r;

  // pack fields, first field lowest
  assign out_tdata = (OutBytes*8)'({dat_r.goaway_last_stream, dat_r.ping_payload,
    dat_r.error_code, dat_r.action, dat_r.frame_end, dat_r.frame_stream,
    dat_r.frame_length, dat_r.frame_flags, dat_r.frame_type, dat_r.header_done,
    dat_r.byte_class});

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (q_ready) begin
      vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) dat_r <= q_data;
  end

endmodule

### rtl/core/http2_frame_receiver.sv
// top level of the http/2 frame receiver
// Receives the client byte stream of one HTTP/2 connection, one byte per
// transfer on in_tdata. Each byte yields exactly one result transfer on
// out_tdata: the byte's role, the fields of the last frame header, end of
// frame, the requested action (ping ack, settings ack, drop) and an error
// code, plus the ping payload and the last GOAWAY stream id.
// Throughput is one byte per cycle while the result queue has room; the parser
// updates its state in the same cycle it accepts a byte. A result passes
// through the result queue and then the output register before it is
// valid on out_tdata. The queue holds QUEUE_DEPTH results.
// When out_tready is low the queue and output register fill and then
// in_tready drops; no result is lost. Reset clears the parser to expect the
// 24-byte client preface and empties the queue and output register.
module http2_frame_receiver import h2r_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // byte_class, header_done, frame_type, frame_flags, frame_length,
  // frame_stream, frame_end, action, error_code, ping_payload, goaway_last_stream
  output logic [OutBytes*8-1:0] out_tdata
);

  logic    f_valid, f_ready, q_valid, q_ready;
  result_t f_data, q_data;

  h2r_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_byte(in_tdata), .in_ready(in_tready),
    .res_valid(f_valid), .res_data(f_data), .res_ready(f_ready)
  );

  h2r_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_data(f_data), .wr_ready(f_ready),
    .rd_valid(q_valid), .rd_data(q_data), .rd_ready(q_ready)
  );

  h2r_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_ready,
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule

### rtl/core/h2r_checker.sv
// port checker for the http/2 frame receiver
`include "http2_frame_receiver_defines.svh"
module h2r_checker import h2r_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [7:0]            in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OutBytes*8-1:0] out_tdata
);

  // offered byte holds until taken
  `H2R_ASSERT_NEXT(a_in_hold, clk, rst_n, in_tvalid && !in_tready,
    in_tvalid && $stable(in_tdata))
  // stalled result holds
  `H2R_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  // ping payload only with a ping ack request
  `H2R_ASSERT_IMP(a_ping_act, clk, rst_n, out_tvalid && out_tdata[145:82] != '0,
    out_tdata[78:77] == ACT_PING)
  // drop always carries an error code
  `H2R_ASSERT_IMP(a_drop_err, clk, rst_n, out_tvalid && out_tdata[78:77] == ACT_DROP,
    out_tdata[81:79] != ERR_NONE)
  // dead bytes request no action
  `H2R_ASSERT_IMP(a_dead_act, clk, rst_n, out_tvalid && out_tdata[3:0] == CLS_DEAD,
    out_tdata[78:77] == ACT_NONE)

endmodule

bind http2_frame_receiver h2r_checker u_h2r_checker (.*);
